// ===== src/tdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants of the full-TOC descriptor parser.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [3:0]  ADR_SKIP   = 4'h5;
  localparam logic [7:0]  PT_FIRST   = 8'hA0;
  localparam logic [7:0]  PT_LAST    = 8'hA1;
  localparam logic [7:0]  PT_LEADOUT = 8'hA2;
  localparam logic [3:0]  DESC_LAST  = 4'd10;   // position of the 11th descriptor byte
  localparam logic [3:0]  LEN_REM_OK = 4'd2;    // required length mod 11
  localparam logic [7:0]  TRACK_LIMIT_RST = 8'd100;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

  localparam logic [2:0] KIND_TRACK   = 3'd0;
  localparam logic [2:0] KIND_FIRST   = 3'd1;
  localparam logic [2:0] KIND_LAST    = 3'd2;
  localparam logic [2:0] KIND_LEADOUT = 3'd3;
  localparam logic [2:0] KIND_STATUS  = 3'd4;

  localparam logic [7:0] STAT_OK        = 8'd0;
  localparam logic [7:0] STAT_TRUNCATED = 8'd1;
  localparam logic [7:0] STAT_CORRUPTED = 8'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] session;
    logic [3:0] adr;
    logic [3:0] control;
    logic [7:0] point;
    logic [7:0] a_min;
    logic [7:0] a_sec;
    logic [7:0] a_frame;
    logic [7:0] p_min;
    logic [7:0] p_sec;
    logic [7:0] p_frame;
    logic       is_final;
  } rec_t;

  // one queue entry: what a single input byte produced
  typedef struct packed {
    logic has_desc;
    rec_t desc;
    logic has_stat;
    rec_t stat;
  } job_t;

endpackage
`default_nettype wire

// ===== src/tdp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_front
// Byte parser: header, descriptor assembly, classification, status.
// ----------------------------------------------------------------------------
module tdp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_stream,
  input  wire logic [7:0]    track_limit,
  output tdp_pkg::job_t      job,
  output logic               push
);

  // x mod 11 for x < 512 by reciprocal multiply (373/4096 ~ 1/11)
  function automatic logic [3:0] mod11(input logic [8:0] v);
    logic [17:0] p;
    logic [5:0]  q;
    logic [9:0]  r;
    p = 18'(v) * 18'd373;
    q = p[17:12];
    r = 10'(v) - 10'(q) * 10'd11;
    return r[3:0];
  endfunction

  logic [16:0] byte_count_r, byte_count_nxt;
  logic [15:0] data_length_r, data_length_nxt;
  logic        length_bad_r, length_bad_nxt;
  logic [3:0]  hi_mod_r, hi_mod_nxt;
  logic [3:0]  desc_pos_r, desc_pos_nxt;
  logic [7:0]  desc_r [10];
  logic [7:0]  sess_first_r, sess_first_nxt;
  logic [7:0]  sess_last_r, sess_last_nxt;
  logic [7:0]  first_trk_r, first_trk_nxt;
  logic [7:0]  last_trk_r, last_trk_nxt;

  logic        in_desc;
  logic        desc_wr;
  logic        emit_desc;
  logic [2:0]  kind;
  logic        truncated;
  logic [8:0]  len_fold;

  assign in_desc = (byte_count_r >= 17'd4) && (byte_count_r < 17'(data_length_r) + 17'd2);
  assign desc_wr = accept && in_desc && (desc_pos_r != tdp_pkg::DESC_LAST);
  assign len_fold = 9'(hi_mod_r) * 9'd3 + 9'(data_byte);  // 256 mod 11 = 3

  always_comb begin
    byte_count_nxt  = byte_count_r;
    data_length_nxt = data_length_r;
    length_bad_nxt  = length_bad_r;
    hi_mod_nxt      = hi_mod_r;
    desc_pos_nxt    = desc_pos_r;
    sess_first_nxt  = sess_first_r;
    sess_last_nxt   = sess_last_r;
    first_trk_nxt   = first_trk_r;
    last_trk_nxt    = last_trk_r;
    emit_desc       = 1'b0;
    kind            = tdp_pkg::KIND_TRACK;
    push            = 1'b0;
    job             = '0;
    truncated       = 1'b0;

    if (accept) begin
      if (byte_count_r == 17'd0) begin
        data_length_nxt = {data_byte, 8'h00};
        hi_mod_nxt      = mod11({1'b0, data_byte});
      end else if (byte_count_r == 17'd1) begin
        data_length_nxt = {data_length_r[15:8], data_byte};
        length_bad_nxt  = (mod11(len_fold) != tdp_pkg::LEN_REM_OK);
      end else if (byte_count_r == 17'd2) begin
        sess_first_nxt = data_byte;
      end else if (byte_count_r == 17'd3) begin
        sess_last_nxt = data_byte;
      end else if (in_desc) begin
        if (desc_pos_r != tdp_pkg::DESC_LAST) begin
          desc_pos_nxt = desc_pos_r + 4'd1;
        end else begin
          desc_pos_nxt = '0;
          if (!length_bad_r && desc_r[1][7:4] != tdp_pkg::ADR_SKIP) begin
            emit_desc = 1'b1;
            if (desc_r[3] < track_limit) begin
              kind = tdp_pkg::KIND_TRACK;
            end else if (desc_r[3] == tdp_pkg::PT_FIRST) begin
              kind = tdp_pkg::KIND_FIRST;
              if (desc_r[8] != 8'd0 &&
                  (first_trk_r == 8'd0 || desc_r[8] < first_trk_r)) begin
                first_trk_nxt = desc_r[8];
              end
            end else if (desc_r[3] == tdp_pkg::PT_LAST) begin
              kind = tdp_pkg::KIND_LAST;
              if (desc_r[8] > last_trk_r) begin
                last_trk_nxt = desc_r[8];
              end
            end else if (desc_r[3] == tdp_pkg::PT_LEADOUT) begin
              kind = tdp_pkg::KIND_LEADOUT;
            end else begin
              emit_desc = 1'b0;   // unknown point: drop it
            end
          end
        end
      end
      if (byte_count_r != tdp_pkg::COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 17'd1;
      end

      job.has_desc      = emit_desc;
      job.desc.kind     = kind;
      job.desc.session  = desc_r[0];
      job.desc.adr      = desc_r[1][7:4];
      job.desc.control  = desc_r[1][3:0];
      job.desc.point    = desc_r[3];
      job.desc.a_min    = desc_r[4];
      job.desc.a_sec    = desc_r[5];
      job.desc.a_frame  = desc_r[6];
      job.desc.p_min    = desc_r[8];
      job.desc.p_sec    = (kind == tdp_pkg::KIND_LAST) ? 8'd0 : desc_r[9];
      job.desc.p_frame  = (kind == tdp_pkg::KIND_FIRST || kind == tdp_pkg::KIND_LAST) ?
                          8'd0 : data_byte;
      job.desc.is_final = 1'b0;

      truncated = (byte_count_nxt < 17'd4) ||
                  (byte_count_nxt < 17'(data_length_nxt) + 17'd2);
      job.has_stat      = end_of_stream;
      job.stat.kind     = tdp_pkg::KIND_STATUS;
      job.stat.session  = sess_first_nxt;
      job.stat.point    = truncated ? tdp_pkg::STAT_TRUNCATED :
                          length_bad_nxt ? tdp_pkg::STAT_CORRUPTED : tdp_pkg::STAT_OK;
      job.stat.a_min    = sess_last_nxt;
      job.stat.a_sec    = first_trk_nxt;
      job.stat.a_frame  = last_trk_nxt;
      job.stat.is_final = 1'b1;

      push = emit_desc || end_of_stream;

      if (end_of_stream) begin
        byte_count_nxt  = '0;
        data_length_nxt = '0;
        length_bad_nxt  = 1'b0;
        hi_mod_nxt      = '0;
        desc_pos_nxt    = '0;
        sess_first_nxt  = '0;
        sess_last_nxt   = '0;
        first_trk_nxt   = '0;
        last_trk_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      data_length_r <= '0;
      length_bad_r  <= 1'b0;
      hi_mod_r      <= '0;
      desc_pos_r    <= '0;
      sess_first_r  <= '0;
      sess_last_r   <= '0;
      first_trk_r   <= '0;
      last_trk_r    <= '0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      data_length_r <= data_length_nxt;
      length_bad_r  <= length_bad_nxt;
      hi_mod_r      <= hi_mod_nxt;
      desc_pos_r    <= desc_pos_nxt;
      sess_first_r  <= sess_first_nxt;
      sess_last_r   <= sess_last_nxt;
      first_trk_r   <= first_trk_nxt;
      last_trk_r    <= last_trk_nxt;
    end
  end

  // descriptor byte buffer, payload only
  always_ff @(posedge clk) begin
    if (desc_wr) begin
      desc_r[desc_pos_r] <= data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/tdp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_queue
// Small FIFO of parsed jobs between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module tdp_queue #(
  parameter int unsigned DEPTH = tdp_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  tdp_pkg::job_t      din,
  input  wire logic          pop,
  output tdp_pkg::job_t      dout,
  output logic               full,
  output logic               empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tdp_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== src/tdp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_back
// Output sequencer: plays out the descriptor and/or status record of a job.
// ----------------------------------------------------------------------------
module tdp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  tdp_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tdp_pkg::rec_t      out_rec
);

  logic          busy_r;
  logic          desc_pend_r;
  logic          stat_pend_r;
  tdp_pkg::rec_t desc_r;
  tdp_pkg::rec_t stat_r;
  logic          out_acc;
  logic          job_done;

  assign out_valid = busy_r;
  assign out_rec   = desc_pend_r ? desc_r : stat_r;
  assign out_acc   = busy_r && !out_stall;
  // the job ends when its last pending record goes out
  assign job_done  = out_acc && !(desc_pend_r && stat_pend_r);
  assign q_pop     = !q_empty && (!busy_r || job_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      desc_pend_r <= 1'b0;
      stat_pend_r <= 1'b0;
    end else if (q_pop) begin
      busy_r      <= 1'b1;
      desc_pend_r <= q_job.has_desc;
      stat_pend_r <= q_job.has_stat;
    end else if (job_done) begin
      busy_r      <= 1'b0;
      desc_pend_r <= 1'b0;
      stat_pend_r <= 1'b0;
    end else if (out_acc) begin
      desc_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_job.desc;
      stat_r <= q_job.stat;
    end
  end

endmodule
`default_nettype wire

// ===== src/cd_full_toc_descriptor_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cd_full_toc_descriptor_parser
// Parses a full-TOC response byte stream into decoded descriptor records
// and one closing status record per response.
// ----------------------------------------------------------------------------
// Bytes are taken at one per clock while the job queue is not full. The
// parser classifies each byte in the cycle it is accepted and queues what it
// produced (at most one descriptor record and one status record) in a
// QUEUE_DEPTH-entry job queue; the output sequencer sends one record per
// clock while out_stall is low, so a byte that closes both a descriptor and
// the stream gives two records in turn. in_stall rises only while the job
// queue is full. track_limit is at byte address 0.
module cd_full_toc_descriptor_parser #(
  parameter int unsigned QUEUE_DEPTH = tdp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_stream,
  // record output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_session,
  output logic [3:0]       out_adr,
  output logic [3:0]       out_control,
  output logic [7:0]       out_point,
  output logic [7:0]       out_a_min,
  output logic [7:0]       out_a_sec,
  output logic [7:0]       out_a_frame,
  output logic [7:0]       out_p_min,
  output logic [7:0]       out_p_sec,
  output logic [7:0]       out_p_frame,
  output logic             out_is_final
);

  logic [7:0]    track_limit_r;
  logic          cfg_wr;
  logic          in_acc;
  logic          push;
  logic          q_full, q_empty, q_pop;
  tdp_pkg::job_t front_job, q_job;
  tdp_pkg::rec_t rec;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {24'd0, track_limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_limit_r <= tdp_pkg::TRACK_LIMIT_RST;
    end else if (cfg_wr) begin
      track_limit_r <= cfg_pwdata[7:0];
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  tdp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .track_limit   (track_limit_r),
    .job           (front_job),
    .push          (push)
  );

  tdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_job),
    .pop   (q_pop),
    .dout  (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  tdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (rec)
  );

  assign out_kind     = rec.kind;
  assign out_session  = rec.session;
  assign out_adr      = rec.adr;
  assign out_control  = rec.control;
  assign out_point    = rec.point;
  assign out_a_min    = rec.a_min;
  assign out_a_sec    = rec.a_sec;
  assign out_a_frame  = rec.a_frame;
  assign out_p_min    = rec.p_min;
  assign out_p_sec    = rec.p_sec;
  assign out_p_frame  = rec.p_frame;
  assign out_is_final = rec.is_final;

endmodule
`default_nettype wire
